// ===== design/posup_pkg.sv =====
package posup_pkg;

    // Phase codes of the short and over-voltage state machines; only PH_IDLE is shared by both.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DELAY = 2'd1;
    localparam logic [1:0] PH_SHORT = 2'd2;
    localparam logic [1:0] PH_PRE   = 2'd1;
    localparam logic [1:0] PH_OV    = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SHORT_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_SHORT_CONFIRM_TICKS = 3'd1;
    localparam logic [2:0] REG_OUTPUT_OV_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_OV_WINDOW_TICKS     = 3'd3;
    localparam logic [2:0] REG_OV_COUNT_NEEDED     = 3'd4;
    localparam logic [2:0] REG_INPUT_UV_SET        = 3'd5;
    localparam logic [2:0] REG_INPUT_OV_SET        = 3'd6;
    localparam logic [2:0] REG_STARTUP_DELAY_TICKS = 3'd7;

    // Request codes.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Register reset values.
    localparam logic [11:0] RST_SHORT_THRESHOLD     = 12'd200;
    localparam logic [9:0]  RST_SHORT_CONFIRM_TICKS = 10'd300;
    localparam logic [11:0] RST_OUTPUT_OV_THRESHOLD = 12'd672;
    localparam logic [7:0]  RST_OV_WINDOW_TICKS     = 8'd100;
    localparam logic [7:0]  RST_OV_COUNT_NEEDED     = 8'd95;
    localparam logic [11:0] RST_INPUT_UV_SET        = 12'd800;
    localparam logic [11:0] RST_INPUT_OV_SET        = 12'd3200;
    localparam logic [11:0] RST_STARTUP_DELAY_TICKS = 12'd3000;

    // Fixed levels and hysteresis margins.
    localparam logic [11:0] MAINS_SHORT_MIN    = 12'd700;
    localparam logic [11:0] NO_LOAD_VOLTAGE    = 12'd1700;
    localparam logic [15:0] LOAD_POWER         = 16'd50;
    localparam logic [12:0] SHORT_RELEASE_HYST = 13'd5;
    localparam logic [12:0] UV_CLEAR_HYST      = 13'd50;
    localparam logic [11:0] OV_CLEAR_HYST      = 12'd100;
    localparam logic [11:0] OUT_OV_CLEAR_HYST  = 12'd50;
    localparam logic [7:0]  HITS_MAX           = 8'd255;

endpackage

// ===== design/power_output_protection_supervisor_core.sv =====
// Each accepted item's result is registered onto the m_ channel in the cycle after it is accepted.
// Throughput: one item per cycle; s_ready stays high while the result register is
// empty or its item is being taken in the same cycle.
// Reset (aresetn low, synchronous): all configuration registers return to their
// defaults, both state machines go idle, all fault flags clear, the startup delay
// restarts at 3000 ticks and the result register empties.
module power_output_protection_supervisor_core
    import posup_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,

    // Input item channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [11:0] s_vout,
    input  logic [11:0] s_vmains,
    input  logic [15:0] s_output_power,
    input  logic        s_pwm_on,
    input  logic [6:0]  s_dim_percent,

    // Result item channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_short_fault,
    output logic        m_output_ov_fault,
    output logic        m_input_uv_fault,
    output logic        m_input_ov_fault,
    output logic        m_pwm_reload
);

    // Configuration registers. The startup delay register has no storage: the
    // startup counter is loaded only at reset, and reset also returns that
    // register to its default, so a written value can never take effect.
    logic [11:0] short_threshold_reg;
    logic [9:0]  short_confirm_ticks_reg;
    logic [11:0] output_ov_threshold_reg;
    logic [7:0]  ov_window_ticks_reg;
    logic [7:0]  ov_count_needed_reg;
    logic [11:0] input_uv_set_reg;
    logic [11:0] input_ov_set_reg;

    // Supervisor state.
    logic [1:0]  short_phase_reg,      short_phase_next;
    logic [9:0]  short_timer_reg,      short_timer_next;
    logic        short_flag_reg,       short_flag_next;
    logic [1:0]  ov_phase_reg,         ov_phase_next;
    logic [7:0]  ov_window_left_reg,   ov_window_left_next;
    logic [7:0]  ov_hits_reg,          ov_hits_next;
    logic        ov_window_active_reg, ov_window_active_next;
    logic        ov_flag_reg,          ov_flag_next;
    logic        mains_low_flag_reg,   mains_low_flag_next;
    logic        mains_high_flag_reg,  mains_high_flag_next;
    logic [11:0] startup_left_reg,     startup_left_next;
    logic        reload_next;

    // Result register.
    logic        m_valid_reg;
    logic        m_short_fault_reg;
    logic        m_output_ov_fault_reg;
    logic        m_input_uv_fault_reg;
    logic        m_input_ov_fault_reg;
    logic        m_pwm_reload_reg;

    logic        s_accept;

    // Configuration is taken in any cycle.
    assign cfg_ready = 1'b1;

    // A new item may enter whenever the result register is free or drains now.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_threshold_reg     <= RST_SHORT_THRESHOLD;
            short_confirm_ticks_reg <= RST_SHORT_CONFIRM_TICKS;
            output_ov_threshold_reg <= RST_OUTPUT_OV_THRESHOLD;
            ov_window_ticks_reg     <= RST_OV_WINDOW_TICKS;
            ov_count_needed_reg     <= RST_OV_COUNT_NEEDED;
            input_uv_set_reg        <= RST_INPUT_UV_SET;
            input_ov_set_reg        <= RST_INPUT_OV_SET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SHORT_THRESHOLD:     short_threshold_reg     <= cfg_data;
                REG_SHORT_CONFIRM_TICKS: short_confirm_ticks_reg <= cfg_data[9:0];
                REG_OUTPUT_OV_THRESHOLD: output_ov_threshold_reg <= cfg_data;
                REG_OV_WINDOW_TICKS:     ov_window_ticks_reg     <= cfg_data[7:0];
                REG_OV_COUNT_NEEDED:     ov_count_needed_reg     <= cfg_data[7:0];
                REG_INPUT_UV_SET:        input_uv_set_reg        <= cfg_data;
                REG_INPUT_OV_SET:        input_ov_set_reg        <= cfg_data;
                REG_STARTUP_DELAY_TICKS: ;
                default: ;
            endcase
        end
    end

    // One pass of the supervisor for the item on the input ports. The checks run
    // in a fixed order and each one sees the flags the previous one left.
    always_comb begin
        short_phase_next      = short_phase_reg;
        short_timer_next      = short_timer_reg;
        short_flag_next       = short_flag_reg;
        ov_phase_next         = ov_phase_reg;
        ov_window_left_next   = ov_window_left_reg;
        ov_hits_next          = ov_hits_reg;
        ov_window_active_next = ov_window_active_reg;
        ov_flag_next          = ov_flag_reg;
        mains_low_flag_next   = mains_low_flag_reg;
        mains_high_flag_next  = mains_high_flag_reg;
        startup_left_next     = startup_left_reg;
        reload_next           = 1'b0;

        if (s_req_type == REQ_TICK) begin
            // A tick only moves the timers and samples the over-voltage window.
            if (short_timer_reg != '0) begin
                short_timer_next = short_timer_reg - 10'd1;
            end
            if (startup_left_reg != '0) begin
                startup_left_next = startup_left_reg - 12'd1;
            end
            if (ov_window_active_reg && ov_window_left_reg != '0) begin
                ov_window_left_next = ov_window_left_reg - 8'd1;
                if (s_vout > output_ov_threshold_reg &&
                    s_output_power > LOAD_POWER && ov_hits_reg != HITS_MAX) begin
                    ov_hits_next = ov_hits_reg + 8'd1;
                end
            end
        end else begin
            // Mains under- and over-voltage with hysteresis, once startup is over.
            if (startup_left_reg == '0) begin
                if (s_vmains < input_uv_set_reg && !mains_low_flag_next) begin
                    mains_low_flag_next = 1'b1;
                    reload_next         = 1'b1;
                end
                if ({1'b0, s_vmains} > ({1'b0, input_uv_set_reg} + UV_CLEAR_HYST) &&
                    mains_low_flag_next) begin
                    mains_low_flag_next = 1'b0;
                    reload_next         = 1'b1;
                end
                if (s_vmains > input_ov_set_reg && !mains_high_flag_next) begin
                    mains_high_flag_next = 1'b1;
                    reload_next          = 1'b1;
                end
                if (input_ov_set_reg >= OV_CLEAR_HYST &&
                    s_vmains < (input_ov_set_reg - OV_CLEAR_HYST) &&
                    mains_high_flag_next) begin
                    mains_high_flag_next = 1'b0;
                    reload_next          = 1'b1;
                end
            end

            // Output short: suspect, wait out the confirm time, then latch.
            unique case (short_phase_reg)
                PH_DELAY: begin
                    if (short_timer_reg != '0) begin
                        if ({1'b0, s_vout} >
                                ({1'b0, short_threshold_reg} + SHORT_RELEASE_HYST) ||
                            mains_low_flag_next || mains_high_flag_next) begin
                            short_flag_next  = 1'b0;
                            short_phase_next = PH_IDLE;
                        end
                    end else if (s_vout <= short_threshold_reg &&
                                 s_vmains > MAINS_SHORT_MIN && s_pwm_on &&
                                 !mains_high_flag_next && !mains_low_flag_next &&
                                 s_dim_percent != '0) begin
                        short_flag_next  = 1'b1;
                        short_phase_next = PH_SHORT;
                    end
                end
                PH_SHORT: begin
                    if ({1'b0, s_vout} >
                            ({1'b0, short_threshold_reg} + SHORT_RELEASE_HYST)) begin
                        short_flag_next  = 1'b0;
                        short_phase_next = PH_IDLE;
                    end
                end
                default: begin
                    // The unused phase code falls back to idle here as well.
                    short_phase_next = PH_IDLE;
                    if (s_vmains > MAINS_SHORT_MIN && s_pwm_on &&
                        !mains_low_flag_next && s_dim_percent != '0 &&
                        s_vout <= short_threshold_reg) begin
                        short_flag_next  = 1'b0;
                        short_timer_next = short_confirm_ticks_reg;
                        short_phase_next = PH_DELAY;
                    end
                end
            endcase

            // Output over-voltage: open a sampling window, judge the hit count
            // when it closes, and release with hysteresis under load.
            unique case (ov_phase_reg)
                PH_PRE: begin
                    if (ov_window_left_reg != '0) begin
                        if (s_vout > NO_LOAD_VOLTAGE &&
                            s_output_power < LOAD_POWER) begin
                            // High voltage with no load is an open output, not
                            // an over-voltage: drop the window.
                            ov_flag_next          = 1'b0;
                            ov_window_active_next = 1'b0;
                            ov_window_left_next   = '0;
                            ov_hits_next          = '0;
                            ov_phase_next         = PH_IDLE;
                        end
                    end else begin
                        if (ov_hits_reg > ov_count_needed_reg) begin
                            ov_flag_next  = 1'b1;
                            reload_next   = 1'b1;
                            ov_phase_next = PH_OV;
                        end else begin
                            ov_flag_next  = 1'b0;
                            ov_phase_next = PH_IDLE;
                        end
                        ov_window_active_next = 1'b0;
                        ov_window_left_next   = '0;
                        ov_hits_next          = '0;
                    end
                end
                PH_OV: begin
                    if (output_ov_threshold_reg >= OUT_OV_CLEAR_HYST &&
                        s_vout < (output_ov_threshold_reg - OUT_OV_CLEAR_HYST) &&
                        s_output_power > LOAD_POWER) begin
                        ov_flag_next  = 1'b0;
                        reload_next   = 1'b1;
                        ov_phase_next = PH_IDLE;
                    end
                end
                default: begin
                    ov_phase_next = PH_IDLE;
                    if (s_vout > output_ov_threshold_reg &&
                        s_output_power > LOAD_POWER) begin
                        ov_window_active_next = 1'b1;
                        ov_window_left_next   = ov_window_ticks_reg;
                        ov_hits_next          = '0;
                        ov_phase_next         = PH_PRE;
                    end
                end
            endcase
        end
    end

    // State and result update on each accepted item. The result flags are reset
    // with the state so they always mirror the current fault flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_phase_reg       <= PH_IDLE;
            short_timer_reg       <= '0;
            short_flag_reg        <= 1'b0;
            ov_phase_reg          <= PH_IDLE;
            ov_window_left_reg    <= RST_OV_WINDOW_TICKS;
            ov_hits_reg           <= '0;
            ov_window_active_reg  <= 1'b0;
            ov_flag_reg           <= 1'b0;
            mains_low_flag_reg    <= 1'b0;
            mains_high_flag_reg   <= 1'b0;
            startup_left_reg      <= RST_STARTUP_DELAY_TICKS;
            m_valid_reg           <= 1'b0;
            m_short_fault_reg     <= 1'b0;
            m_output_ov_fault_reg <= 1'b0;
            m_input_uv_fault_reg  <= 1'b0;
            m_input_ov_fault_reg  <= 1'b0;
            m_pwm_reload_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                short_phase_reg       <= short_phase_next;
                short_timer_reg       <= short_timer_next;
                short_flag_reg        <= short_flag_next;
                ov_phase_reg          <= ov_phase_next;
                ov_window_left_reg    <= ov_window_left_next;
                ov_hits_reg           <= ov_hits_next;
                ov_window_active_reg  <= ov_window_active_next;
                ov_flag_reg           <= ov_flag_next;
                mains_low_flag_reg    <= mains_low_flag_next;
                mains_high_flag_reg   <= mains_high_flag_next;
                startup_left_reg      <= startup_left_next;
                m_valid_reg           <= 1'b1;
                m_short_fault_reg     <= short_flag_next;
                m_output_ov_fault_reg <= ov_flag_next;
                m_input_uv_fault_reg  <= mains_low_flag_next;
                m_input_ov_fault_reg  <= mains_high_flag_next;
                m_pwm_reload_reg      <= reload_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_short_fault     = m_short_fault_reg;
    assign m_output_ov_fault = m_output_ov_fault_reg;
    assign m_input_uv_fault  = m_input_uv_fault_reg;
    assign m_input_ov_fault  = m_input_ov_fault_reg;
    assign m_pwm_reload      = m_pwm_reload_reg;

endmodule

// ===== design/posup_checker.sv =====
module posup_checker
    import posup_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_req_type,
    input logic m_valid,
    input logic m_ready,
    input logic m_short_fault,
    input logic m_output_ov_fault,
    input logic m_input_uv_fault,
    input logic m_input_ov_fault,
    input logic m_pwm_reload
);

    // No result item is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_short_fault) &&
            $stable(m_output_ov_fault) && $stable(m_input_uv_fault) &&
            $stable(m_input_ov_fault) && $stable(m_pwm_reload)))
        else $error("stalled result item changed");

    // A tick item produces its result next cycle without a reload request.
    a_tick_no_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_TICK) |=> (m_valid && !m_pwm_reload))
        else $error("tick result missing or requests reload");

    // A tick never changes any fault flag.
    a_tick_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_TICK) |=>
            ($stable(m_short_fault) && $stable(m_output_ov_fault) &&
             $stable(m_input_uv_fault) && $stable(m_input_ov_fault)))
        else $error("tick changed a fault flag");

    // The input side never stalls while the result side drains.
    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind power_output_protection_supervisor_core posup_checker u_posup_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_req_type        (s_req_type),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_short_fault     (m_short_fault),
    .m_output_ov_fault (m_output_ov_fault),
    .m_input_uv_fault  (m_input_uv_fault),
    .m_input_ov_fault  (m_input_ov_fault),
    .m_pwm_reload      (m_pwm_reload)
);
